// ===== rtl/cnfs_pkg.sv =====
// Shared constants and types for the complex NCO frequency shifter.
package cnfs_pkg;

    localparam int SAMPLE_BITS_DEFAULT   = 16;
    localparam int OSC_FRAC_BITS_DEFAULT = 16;

    // Depth of the sample queue between the front and the mixer.
    localparam int QUEUE_DEPTH = 2;

    // Register indexes of the configuration port.
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROTATION_COSINE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ROTATION_SINE   = 1'b1;

    // Status of the queue head as seen by the mixer.
    typedef struct packed {
        logic avail;
        logic block_end;
    } head_status_t;

endpackage

// ===== rtl/cnfs_front.sv =====
// Input front: accepts sample transactions into a short queue ahead of the mixer.
module cnfs_front #(
    parameter int SAMPLE_BITS = cnfs_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_real,
    input  logic signed [SAMPLE_BITS-1:0] sample_imag,
    input  logic                          block_end_in,
    output logic signed [SAMPLE_BITS-1:0] head_real,
    output logic signed [SAMPLE_BITS-1:0] head_imag,
    output cnfs_pkg::head_status_t        head_status,
    input  logic                          head_pop
);

    localparam int PtrBits   = (cnfs_pkg::QUEUE_DEPTH > 1) ? $clog2(cnfs_pkg::QUEUE_DEPTH) : 1;
    localparam int CountBits = $clog2(cnfs_pkg::QUEUE_DEPTH + 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic                          last;
    } entry_t;

    entry_t               queue_mem [cnfs_pkg::QUEUE_DEPTH];
    logic [PtrBits-1:0]   wr_ptr_reg;
    logic [PtrBits-1:0]   wr_ptr_next;
    logic [PtrBits-1:0]   rd_ptr_reg;
    logic [PtrBits-1:0]   rd_ptr_next;
    logic [CountBits-1:0] count_reg;
    logic [CountBits-1:0] count_next;
    logic                 push;
    entry_t               head_entry;

    assign sample_stall = (count_reg == CountBits'(cnfs_pkg::QUEUE_DEPTH));
    assign push         = sample_valid && !sample_stall;

    assign head_entry            = queue_mem[rd_ptr_reg];
    assign head_real             = head_entry.re;
    assign head_imag             = head_entry.im;
    assign head_status.avail     = (count_reg != '0);
    assign head_status.block_end = head_entry.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrBits'(cnfs_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (head_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrBits'(cnfs_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, head_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= '{re: sample_real, im: sample_imag, last: block_end_in};
        end
    end

    // the mixer only pops a queue that holds something
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> head_status.avail)
        else $error("pop from empty sample queue");

endmodule

// ===== rtl/cnfs_mixer.sv =====
// Back end: quadrature oscillator recurrence, complex mixer and output register.
module cnfs_mixer #(
    parameter int SAMPLE_BITS   = cnfs_pkg::SAMPLE_BITS_DEFAULT,
    parameter int OSC_FRAC_BITS = cnfs_pkg::OSC_FRAC_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cnfs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic signed [OSC_FRAC_BITS+1:0]        cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]          head_real,
    input  logic signed [SAMPLE_BITS-1:0]          head_imag,
    input  cnfs_pkg::head_status_t                 head_status,
    output logic                                   head_pop,
    output logic                                   shifted_valid,
    input  logic                                   shifted_stall,
    output logic signed [SAMPLE_BITS-1:0]          shifted_real,
    output logic signed [SAMPLE_BITS-1:0]          shifted_imag,
    output logic                                   block_end_out
);

    localparam int OscBits  = OSC_FRAC_BITS + 2;
    localparam int OscProdW = 2 * OscBits;
    localparam int SmpProdW = SAMPLE_BITS + OscBits;
    localparam int WideW    = ((OscProdW > SmpProdW) ? OscProdW : SmpProdW) + 2;

    localparam longint GainFull = (199 * (longint'(1) << OSC_FRAC_BITS) + 50) / 100;
    localparam logic signed [OscBits-1:0] GainConst = OscBits'(GainFull);
    localparam logic signed [OscBits-1:0] OscOne    = OscBits'(longint'(1) << OSC_FRAC_BITS);
    localparam logic signed [WideW-1:0]   RoundHalf =
        WideW'(longint'(1) << (OSC_FRAC_BITS - 1));

    typedef enum logic [1:0] {
        ST_WAIT = 2'b01,
        ST_MIX  = 2'b10
    } state_t;

    // round half up, drop the fraction bits of the oscillator format
    function automatic logic signed [WideW-1:0] round_q(input logic signed [WideW-1:0] v);
        round_q = (v + RoundHalf) >>> OSC_FRAC_BITS;
    endfunction

    function automatic logic signed [OscBits-1:0] sat_osc(input logic signed [WideW-1:0] v);
        logic [WideW-OscBits:0] top;
        top = v[WideW-1:OscBits-1];
        if (&top || ~|top)
            sat_osc = v[OscBits-1:0];
        else if (v[WideW-1])
            sat_osc = {1'b1, {(OscBits-1){1'b0}}};
        else
            sat_osc = {1'b0, {(OscBits-1){1'b1}}};
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
        input logic signed [WideW-1:0] v);
        logic [WideW-SAMPLE_BITS:0] top;
        top = v[WideW-1:SAMPLE_BITS-1];
        if (&top || ~|top)
            sat_smp = v[SAMPLE_BITS-1:0];
        else if (v[WideW-1])
            sat_smp = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            sat_smp = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    endfunction

    function automatic logic signed [WideW-1:0] ext_oo(input logic signed [OscProdW-1:0] v);
        ext_oo = {{(WideW-OscProdW){v[OscProdW-1]}}, v};
    endfunction

    function automatic logic signed [WideW-1:0] ext_so(input logic signed [SmpProdW-1:0] v);
        ext_so = {{(WideW-SmpProdW){v[SmpProdW-1]}}, v};
    endfunction

    state_t                        state_reg;
    state_t                        state_next;
    logic signed [OscBits-1:0]     cos_reg;
    logic signed [OscBits-1:0]     sin_reg;
    logic signed [OscBits-1:0]     osc_re_reg;
    logic signed [OscBits-1:0]     osc_im_reg;
    logic signed [OscBits-1:0]     osc_re_next;
    logic signed [OscBits-1:0]     osc_im_next;
    logic signed [OscBits-1:0]     pre_reg;
    logic signed [OscBits-1:0]     pim_reg;
    logic signed [OscBits-1:0]     gain_reg;
    logic signed [OscBits-1:0]     pre_next;
    logic signed [OscBits-1:0]     pim_next;
    logic signed [OscBits-1:0]     gain_next;
    logic signed [SAMPLE_BITS-1:0] smp_re_reg;
    logic signed [SAMPLE_BITS-1:0] smp_im_reg;
    logic                          smp_last_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_re_reg;
    logic signed [SAMPLE_BITS-1:0] out_im_reg;
    logic                          out_last_reg;
    logic signed [SAMPLE_BITS-1:0] out_re_next;
    logic signed [SAMPLE_BITS-1:0] out_im_next;

    logic signed [OscProdW-1:0]    p_rc;
    logic signed [OscProdW-1:0]    p_is;
    logic signed [OscProdW-1:0]    p_ic;
    logic signed [OscProdW-1:0]    p_rs;
    logic signed [OscProdW-1:0]    p_rr;
    logic signed [OscProdW-1:0]    p_ii;
    logic signed [OscProdW-1:0]    p_gr;
    logic signed [OscProdW-1:0]    p_gi;
    logic signed [SmpProdW-1:0]    p_sr_pr;
    logic signed [SmpProdW-1:0]    p_si_pi;
    logic signed [SmpProdW-1:0]    p_sr_pi;
    logic signed [SmpProdW-1:0]    p_si_pr;
    logic signed [WideW-1:0]       mag;

    logic take;
    logic out_free;
    logic fire;

    assign cfg_ready = 1'b1;

    assign take     = (state_reg == ST_WAIT) && head_status.avail;
    assign head_pop = take;
    assign out_free = !out_valid_reg || !shifted_stall;
    assign fire     = (state_reg == ST_MIX) && out_free;

    // first step: phasor and amplitude gain from the current oscillator
    always_comb
    begin
        p_rc      = osc_re_reg * cos_reg;
        p_is      = osc_im_reg * sin_reg;
        p_ic      = osc_im_reg * cos_reg;
        p_rs      = osc_re_reg * sin_reg;
        p_rr      = osc_re_reg * osc_re_reg;
        p_ii      = osc_im_reg * osc_im_reg;
        pre_next  = sat_osc(round_q(ext_oo(p_rc) - ext_oo(p_is)));
        pim_next  = sat_osc(round_q(ext_oo(p_ic) + ext_oo(p_rs)));
        mag       = round_q(ext_oo(p_rr) + ext_oo(p_ii));
        gain_next = sat_osc({{(WideW-OscBits){1'b0}}, GainConst} - mag);
    end

    // second step: next oscillator and mixed sample
    always_comb
    begin
        p_gr        = gain_reg * pre_reg;
        p_gi        = gain_reg * pim_reg;
        osc_re_next = sat_osc(round_q(ext_oo(p_gr)));
        osc_im_next = sat_osc(round_q(ext_oo(p_gi)));
        p_sr_pr     = smp_re_reg * pre_reg;
        p_si_pi     = smp_im_reg * pim_reg;
        p_sr_pi     = smp_re_reg * pim_reg;
        p_si_pr     = smp_im_reg * pre_reg;
        out_re_next = sat_smp(round_q(ext_so(p_sr_pr) - ext_so(p_si_pi)));
        out_im_next = sat_smp(round_q(ext_so(p_sr_pi) + ext_so(p_si_pr)));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_WAIT: if (take) state_next = ST_MIX;
            ST_MIX:  if (fire) state_next = ST_WAIT;
            default: state_next = ST_WAIT;
        endcase
        out_valid_next = fire || (out_valid_reg && shifted_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT;
            out_valid_reg <= 1'b0;
            osc_re_reg    <= OscOne;
            osc_im_reg    <= '0;
            cos_reg       <= OscOne;
            sin_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                osc_re_reg <= osc_re_next;
                osc_im_reg <= osc_im_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    cnfs_pkg::REG_ROTATION_COSINE: cos_reg <= cfg_data;
                    cnfs_pkg::REG_ROTATION_SINE:   sin_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pre_reg      <= pre_next;
            pim_reg      <= pim_next;
            gain_reg     <= gain_next;
            smp_re_reg   <= head_real;
            smp_im_reg   <= head_imag;
            smp_last_reg <= head_status.block_end;
        end
        if (fire)
        begin
            out_re_reg   <= out_re_next;
            out_im_reg   <= out_im_next;
            out_last_reg <= smp_last_reg;
        end
    end

    assign shifted_valid = out_valid_reg;
    assign shifted_real  = out_re_reg;
    assign shifted_imag  = out_im_reg;
    assign block_end_out = out_last_reg;

    // oscillator advances only when a result is produced
    a_osc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(osc_re_reg) && $stable(osc_im_reg))
        else $error("oscillator changed without a result");

    // a popped sample is in the mix step on the next cycle
    a_pop_then_mix: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |=> state_reg == ST_MIX)
        else $error("popped sample not mixed");

    // a produced result is visible on the output next cycle
    a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> shifted_valid && state_reg == ST_WAIT)
        else $error("result not presented");

endmodule

// ===== rtl/complex_nco_frequency_shifter.sv =====
// Top level of the complex NCO frequency shifter.
// Shifts a complex Q1.(SAMPLE_BITS-1) sample stream in frequency by mixing it with a
// recursive quadrature oscillator (Q2.OSC_FRAC_BITS) that starts at 1+0j after reset.
// Per sample the oscillator is rotated by rotation_cosine/rotation_sine (register 0
// and 1 on the cfg port, Q2.OSC_FRAC_BITS, reset 1.0 and 0) to form the phasor, the
// sample is multiplied by it, and the phasor scaled by (1.99 - |osc|^2) becomes the
// next oscillator. Outputs are rounded half up and saturated; block_end passes along.
// Samples are handled one at a time: the oscillator recurrence is two multiplier
// levels deep (rotate, then gain scaling) with a register between them; a queued
// sample is taken in the wait state and its result is registered in the mix state
// once the output is free. A 2-entry queue sits in front of the mixer and the result
// sits in an output register, so input and output stall independently. cfg_ready
// is always high; write configuration only while no sample is in flight.
module complex_nco_frequency_shifter #(
    parameter int SAMPLE_BITS   = cnfs_pkg::SAMPLE_BITS_DEFAULT,
    parameter int OSC_FRAC_BITS = cnfs_pkg::OSC_FRAC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cnfs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic signed [OSC_FRAC_BITS+1:0]     cfg_data,
    // sample input channel
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample_real,
    input  logic signed [SAMPLE_BITS-1:0]       sample_imag,
    input  logic                                block_end_in,
    // shifted output channel
    output logic                                shifted_valid,
    input  logic                                shifted_stall,
    output logic signed [SAMPLE_BITS-1:0]       shifted_real,
    output logic signed [SAMPLE_BITS-1:0]       shifted_imag,
    output logic                                block_end_out
);

    logic signed [SAMPLE_BITS-1:0] head_real;
    logic signed [SAMPLE_BITS-1:0] head_imag;
    cnfs_pkg::head_status_t        head_status;
    logic                          head_pop;

    // front: takes sample transactions into the queue
    cnfs_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_real  (sample_real),
        .sample_imag  (sample_imag),
        .block_end_in (block_end_in),
        .head_real    (head_real),
        .head_imag    (head_imag),
        .head_status  (head_status),
        .head_pop     (head_pop)
    );

    // back: oscillator, mixer and output register
    cnfs_mixer #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .OSC_FRAC_BITS (OSC_FRAC_BITS)
    ) u_mixer (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .head_real     (head_real),
        .head_imag     (head_imag),
        .head_status   (head_status),
        .head_pop      (head_pop),
        .shifted_valid (shifted_valid),
        .shifted_stall (shifted_stall),
        .shifted_real  (shifted_real),
        .shifted_imag  (shifted_imag),
        .block_end_out (block_end_out)
    );

endmodule
